>>> sv/bsff_pkg.sv
`default_nettype none
package bsff_pkg;

	localparam int POS_W = 12;
	localparam int CNT_W = 13;

	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

	typedef struct packed {
		logic             cmd;
		logic [POS_W-1:0] position;
		logic             bit_value;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] result_index;
		logic             error;
	} rsp_t;

endpackage
`default_nettype wire

>>> sv/bitmap_set_and_find_first_unit.sv
// Allocation bitmap with bit set/clear and find-first-match, MSB first within each byte.
// Request channel (req_valid/req_ready, req): cmd set writes bit_value at position and
// echoes the position; cmd find scans upward from position for the first bit equal to
// bit_value. Response channel (rsp_valid/rsp_ready, rsp) carries result_index and error;
// an error word has result_index zero.
// cfg_we/cfg_wdata write bit_count; positions at or above it are invalid.
// One command is in work at a time. Out-of-range: the command goes straight to done,
// which loads the response once the output register is free. Set: read, then modify
// and write back one byte. Find: the first byte is read at accept, then the scan goes
// on one byte per cycle through the memory read port until a match or the count ends.
// req_ready returns as the response is loaded into the output register.
// After reset the memory is cleared one byte per cycle, all (MAX_BITS+7)/8 bytes (512 by
// default), with req_ready low; bit_count returns to 4096.
// A response waits in its output register while rsp_ready is low; the next request is
// taken meanwhile and its response is held until the register frees.
`default_nettype none
module bitmap_set_and_find_first_unit #(
	parameter int MAX_BITS = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bsff_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire bsff_pkg::req_t             req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output bsff_pkg::rsp_t                  rsp
);

	localparam int DEPTH = (MAX_BITS + 7) / 8;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	bsff_ctrl #(
		.MAX_BITS(MAX_BITS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	bsff_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
`default_nettype wire

>>> sv/bsff_ram.sv
`default_nettype none
module bsff_ram #(
	parameter int DEPTH = 512,
	parameter int AW = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/bsff_ctrl.sv
`default_nettype none
module bsff_ctrl #(
	parameter int MAX_BITS = 4096,
	parameter int AW = 9
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [bsff_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire bsff_pkg::req_t            req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	output bsff_pkg::rsp_t                 rsp,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output logic [7:0]                     mem_wdata,
	output logic                           mem_re,
	output logic [AW-1:0]                  mem_raddr,
	input  wire logic [7:0]                mem_rdata
);

	localparam int DEPTH = (MAX_BITS + 7) / 8;
	localparam int KW = (AW + 3 > bsff_pkg::CNT_W) ? AW + 3 : bsff_pkg::CNT_W;
	localparam int BIW = KW - 3;
	localparam bit CAP_ON = (MAX_BITS < (1 << bsff_pkg::CNT_W));
	localparam logic [bsff_pkg::CNT_W-1:0] CAP_VAL = bsff_pkg::CNT_W'(MAX_BITS);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET,
		ST_FIND,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [bsff_pkg::CNT_W-1:0] bit_count_q;
	logic [AW-1:0]              clr_q;
	logic [BIW-1:0]             cur_q;
	logic [2:0]                 off_q;
	logic                       val_q;
	bsff_pkg::rsp_t             res_q;
	bsff_pkg::rsp_t             rsp_q;
	logic                       rsp_valid_q;

	logic [bsff_pkg::CNT_W-1:0] eff_cnt;
	logic [KW-1:0]              cnt_k;
	logic [BIW-1:0]             cnt_byte;
	logic [2:0]                 cnt_rem;
	logic [KW-1:0]              pos_k;
	logic                       accept;
	logic                       pos_bad;
	logic [BIW-1:0]             nxt_byte;
	logic                       nxt_ok;
	logic [7:0]                 hit;
	logic [2:0]                 hit_j;
	logic                       any_hit;
	logic [KW-1:0]              hit_k;
	logic [KW-1:0]              set_k;
	logic [7:0]                 bit_mask;

	// positions at or beyond the store never exist
	assign eff_cnt = (CAP_ON && bit_count_q > CAP_VAL) ? CAP_VAL : bit_count_q;
	assign cnt_k = KW'(eff_cnt);
	assign cnt_byte = cnt_k[KW-1:3];
	assign cnt_rem = cnt_k[2:0];

	assign pos_k = KW'(req.position);
	assign pos_bad = (pos_k >= cnt_k);
	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;

	assign nxt_byte = cur_q + BIW'(1);
	assign nxt_ok = ({nxt_byte, 3'b000} < cnt_k);

	// bits of the current word that may match: at or after the start offset, below the count
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			hit[j] = (mem_rdata[7-j] == val_q) && (3'(j) >= off_q)
				&& ((cur_q < cnt_byte) || (3'(j) < cnt_rem));
		end
		hit_j = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (hit[j]) begin
				hit_j = 3'(j);
			end
		end
	end
	assign any_hit = |hit;
	assign hit_k = {cur_q, hit_j};
	assign set_k = {cur_q, off_q};
	assign bit_mask = 8'h80 >> off_q;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = cur_q[AW-1:0];
		mem_wdata = val_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
		mem_re = 1'b0;
		mem_raddr = pos_k[AW+2:3];
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'h00;
			end
			ST_IDLE: begin
				mem_re = accept && !pos_bad;
			end
			ST_SET: begin
				mem_we = 1'b1;
			end
			ST_FIND: begin
				mem_re = !any_hit && nxt_ok;
				mem_raddr = nxt_byte[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			bit_count_q <= bsff_pkg::CNT_RESET;
			clr_q <= '0;
			cur_q <= '0;
			off_q <= '0;
			val_q <= 1'b0;
			res_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bit_count_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cur_q <= pos_k[KW-1:3];
						off_q <= req.position[2:0];
						val_q <= req.bit_value;
						if (pos_bad) begin
							res_q.result_index <= '0;
							res_q.error <= 1'b1;
							state_q <= ST_DONE;
						end else if (req.cmd == bsff_pkg::CMD_SET) begin
							state_q <= ST_SET;
						end else begin
							state_q <= ST_FIND;
						end
					end
				end
				ST_SET: begin
					res_q.result_index <= set_k[bsff_pkg::POS_W-1:0];
					res_q.error <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_FIND: begin
					if (any_hit) begin
						res_q.result_index <= hit_k[bsff_pkg::POS_W-1:0];
						res_q.error <= 1'b0;
						state_q <= ST_DONE;
					end else if (nxt_ok) begin
						cur_q <= nxt_byte;
						off_q <= 3'd0;
					end else begin
						res_q.result_index <= '0;
						res_q.error <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q <= res_q;
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire

>>> tb/bitmap_set_and_find_first_unit_test.sv
`timescale 1ns / 100ps

module bitmap_set_and_find_first_unit_test;

	localparam int MAP_BITS     = 4096;
	localparam int RANDOM_WORDS = 1170;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 300;
	localparam int PRINT_CAP    = 40;

	localparam logic OP_SET  = bsff_pkg::CMD_SET;
	localparam logic OP_FIND = bsff_pkg::CMD_FIND;

	// receiver stall patterns
	localparam int RX_OPEN   = 0;
	localparam int RX_RANDOM = 1;
	localparam int RX_COMB   = 2;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [bsff_pkg::CNT_W-1:0] cfg_wdata = '0;
	logic                       req_valid = 1'b0;
	logic                       req_ready;
	bsff_pkg::req_t             req       = '0;
	logic                       rsp_valid;
	logic                       rsp_ready = 1'b0;
	bsff_pkg::rsp_t             rsp;

	bitmap_set_and_find_first_unit #(
		.MAX_BITS(MAP_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the allocation bitmap and the bit_count register
	bit                         free_map [MAP_BITS];
	logic [bsff_pkg::CNT_W-1:0] bit_limit = bsff_pkg::CNT_RESET;
	bsff_pkg::rsp_t             answers_due [$];

	int mismatches    = 0;
	int answers_seen  = 0;
	int words_sent    = 0;
	int find_words    = 0;
	int error_answers = 0;
	int count_writes  = 0;

	typedef struct packed {
		logic                       new_count;
		logic [bsff_pkg::CNT_W-1:0] count_val;
		logic                       cmd;
		logic [bsff_pkg::POS_W-1:0] pos;
		logic                       val;
		logic                       typed;
		logic [bsff_pkg::POS_W-1:0] want_index;
		logic                       want_error;
	} script_row_t;

	script_row_t script [$];

	function automatic bsff_pkg::rsp_t resolve_request(input bsff_pkg::req_t w);
		bsff_pkg::rsp_t r;
		int             lim;
		int             k;
		r = '0;
		r.error = 1'b1;
		lim = (int'(bit_limit) > MAP_BITS) ? MAP_BITS : int'(bit_limit);
		if (int'(w.position) < lim) begin
			if (w.cmd == OP_SET) begin
				free_map[w.position] = w.bit_value;
				r.result_index = w.position;
				r.error = 1'b0;
			end else begin
				for (k = int'(w.position); k < lim && r.error; k++) begin
					if (free_map[k] == w.bit_value) begin
						r.result_index = k[bsff_pkg::POS_W-1:0];
						r.error = 1'b0;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// offer one word and hold it until the handshake
	task automatic send_word(input bsff_pkg::req_t w, input bit typed,
			input bsff_pkg::rsp_t typed_rsp);
		bsff_pkg::rsp_t p;
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		p = resolve_request(w);
		answers_due.push_back(typed ? typed_rsp : p);
		words_sent++;
		if (w.cmd == OP_FIND)
			find_words++;
		if (p.error)
			error_answers++;
	endtask

	task automatic write_count(input logic [bsff_pkg::CNT_W-1:0] v);
		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		bit_limit = v;
		count_writes++;
	endtask

	always @(posedge clk) begin
		bsff_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			answers_seen++;
			if (answers_due.size() == 0) begin
				report_mismatch("word with nothing expected", int'(rsp.result_index), 0);
			end else begin
				want = answers_due.pop_front();
				if (rsp.result_index !== want.result_index)
					report_mismatch("result_index", int'(rsp.result_index),
						int'(want.result_index));
				if (rsp.error !== want.error)
					report_mismatch("error", int'(rsp.error), int'(want.error));
			end
		end
	end

	// receiver: stretches of stall patterns, plus one long hold-off to back up the block
	initial begin
		int  mode;
		int  left;
		bit  held;
		mode = RX_OPEN;
		left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && answers_seen >= HOLD_AFTER && req_valid) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(RX_OPEN, RX_COMB);
					left = $urandom_range(10, 150);
				end
				left--;
				case (mode)
					RX_OPEN: begin
						rsp_ready <= 1'b1;
					end
					RX_RANDOM: begin
						rsp_ready <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						rsp_ready <= (left % 3 == 0);
					end
				endcase
			end
		end
	end

	initial begin
		#(16_000_000);
		$display("bitmap_set_and_find_first_unit verification failed");
		$finish;
	end

	initial begin
		script_row_t                row;
		bsff_pkg::req_t             w;
		bsff_pkg::rsp_t             t;
		int                         i;
		int                         n;
		int                         burst;
		int                         gap;
		int                         phase_len;
		int                         lim;
		int                         one_bias;
		int                         pick;
		int                         random_sent;
		logic [bsff_pkg::CNT_W-1:0] cnt;
		bit                         big;

		// columns: new_count, count_val, cmd, pos, val, typed, want_index, want_error
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd0,    1'b1, 1'b1, 12'd0,    1'b1});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd0,    1'b0, 1'b1, 12'd0,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd4095, 1'b0, 1'b1, 12'd4095, 1'b0});
		script.push_back('{1'b0, 13'd0,    OP_SET,  12'd0,    1'b1, 1'b1, 12'd0,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_SET,  12'd4095, 1'b1, 1'b1, 12'd4095, 1'b0});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd1,    1'b1, 1'b1, 12'd4095, 1'b0});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd0,    1'b1, 1'b1, 12'd0,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_SET,  12'd7,    1'b1, 1'b1, 12'd7,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_SET,  12'd8,    1'b1, 1'b1, 12'd8,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd1,    1'b1, 1'b0, 12'd0,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd0,    1'b0, 1'b0, 12'd0,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_SET,  12'd0,    1'b0, 1'b1, 12'd0,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd0,    1'b1, 1'b0, 12'd0,    1'b0});
		// empty bitmap
		script.push_back('{1'b1, 13'd0,    OP_SET,  12'd5,    1'b1, 1'b1, 12'd0,    1'b1});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd0,    1'b0, 1'b1, 12'd0,    1'b1});
		// one byte in use: position at the count, scan that runs out
		script.push_back('{1'b1, 13'd8,    OP_SET,  12'd7,    1'b0, 1'b1, 12'd7,    1'b0});
		script.push_back('{1'b0, 13'd0,    OP_SET,  12'd8,    1'b1, 1'b1, 12'd0,    1'b1});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd0,    1'b1, 1'b1, 12'd0,    1'b1});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd3,    1'b0, 1'b0, 12'd0,    1'b0});
		// count above capacity behaves as full size
		script.push_back('{1'b1, 13'd8191, OP_FIND, 12'd9,    1'b1, 1'b1, 12'd4095, 1'b0});
		script.push_back('{1'b0, 13'd0,    OP_SET,  12'd4095, 1'b0, 1'b1, 12'd4095, 1'b0});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd9,    1'b1, 1'b1, 12'd0,    1'b1});
		script.push_back('{1'b1, 13'd4095, OP_SET,  12'd4095, 1'b1, 1'b1, 12'd0,    1'b1});
		script.push_back('{1'b0, 13'd0,    OP_FIND, 12'd4094, 1'b0, 1'b1, 12'd4094, 1'b0});
		script.push_back('{1'b1, 13'd4097, OP_FIND, 12'd4095, 1'b0, 1'b0, 12'd0,    1'b0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// memory clearing pass holds req_ready low
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);

		for (i = 0; i < script.size(); i++) begin
			row = script[i];
			if (row.new_count)
				write_count(row.count_val);
			w.cmd = row.cmd;
			w.position = row.pos;
			w.bit_value = row.val;
			t.result_index = row.want_index;
			t.error = row.want_error;
			send_word(w, row.typed, t);
		end

		random_sent = 0;
		t = '0;
		while (random_sent < RANDOM_WORDS) begin
			pick = $urandom_range(0, 9);
			big = (pick == 0);
			if (big) begin
				case ($urandom_range(0, 3))
					0: cnt = 13'd4096;
					1: cnt = 13'd8191;
					2: cnt = 13'd4095;
					default: cnt = 13'($urandom_range(4097, 8191));
				endcase
				phase_len = $urandom_range(20, 50);
			end else if (pick == 1) begin
				cnt = 13'($urandom_range(0, 8));
				phase_len = $urandom_range(20, 60);
			end else begin
				cnt = 13'($urandom_range(1, 400));
				phase_len = $urandom_range(60, 160);
			end
			one_bias = $urandom_range(0, 4);
			write_count(cnt);
			lim = (int'(cnt) > MAP_BITS) ? MAP_BITS : int'(cnt);
			n = 0;
			while (n < phase_len) begin
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					w.cmd = $urandom_range(0, 1) ? OP_FIND : OP_SET;
					if (lim > 0 && $urandom_range(0, 9) != 0)
						w.position = 12'($urandom_range(0, lim - 1));
					else
						w.position = 12'($urandom_range(0, MAP_BITS - 1));
					// density of set bits varies per phase so scans run short and long
					if (w.cmd == OP_SET)
						w.bit_value = ($urandom_range(0, 3) < one_bias);
					else
						w.bit_value = $urandom_range(0, 1);
					send_word(w, 1'b0, t);
					n++;
					random_sent++;
				end
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				if (gap != 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d finds, %0d sets, %0d expected error words",
			words_sent, find_words, words_sent - find_words, error_answers);
		$display("%0d bit_count writes, %0d response words checked, one long output hold-off",
			count_writes, answers_seen);
		if (mismatches == 0) begin
			$display("bitmap_set_and_find_first_unit verification clean");
		end else begin
			$display("bitmap_set_and_find_first_unit verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/bsff_pkg.sv
sv/bsff_ram.sv
sv/bsff_ctrl.sv
sv/bitmap_set_and_find_first_unit.sv
tb/bitmap_set_and_find_first_unit_test.sv
